// ===== src/vtu_pkg.sv =====
// ----------------------------------------------------------------------------
// vtu_pkg
// Shared types and constants of the vertex transform unit: transform kinds,
// register map, coefficient bundle and pipeline occupancy status.
// ----------------------------------------------------------------------------
package vtu_pkg;

  // channel and register port geometry
  localparam int IO_W       = 32;
  localparam int HALF_W     = 32;
  localparam int CFG_DATA_W = 64;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int ADDR_LSB   = 3;
  localparam int CFG_ADDR_W = REG_IDX_W + ADDR_LSB;

  // transform kind carried with every vector
  typedef enum logic [1:0] {
    KIND_POINT  = 2'd0,
    KIND_NORMAL = 2'd1,
    KIND_ROTATE = 2'd2,
    KIND_PASS   = 2'd3
  } kind_t;

  // register map, one 64-bit register per coefficient pair
  typedef enum logic [REG_IDX_W-1:0] {
    REG_M11_M12  = 3'd0,
    REG_M13_M21  = 3'd1,
    REG_M22_M23  = 3'd2,
    REG_M31_M32  = 3'd3,
    REG_M33_M41  = 3'd4,
    REG_M42_M43  = 3'd5,
    REG_QUAT_X_Y = 3'd6,
    REG_QUAT_Z_W = 3'd7
  } reg_idx_t;

  typedef logic [HALF_W-1:0] half_t;

  // raw coefficient halves as stored in the registers
  typedef struct packed {
    half_t [2:0][2:0] m;   // m[row][col], row-vector convention
    half_t [2:0]      tr;  // translation x, y, z
    half_t            qx;
    half_t            qy;
    half_t            qz;
    half_t            qw;
  } coef_t;

  // valid bits of the two register stages inside a pipeline section
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_occ_t;

  // 1.0 in the low or high half of a register
  localparam logic [CFG_DATA_W-1:0] ONE_LOW  = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] ONE_HIGH = 64'h0001_0000_0000_0000;

  // register values after reset: identity matrix, unit quaternion
  function automatic logic [CFG_DATA_W-1:0] reg_reset(reg_idx_t idx);
    logic [CFG_DATA_W-1:0] val;
    unique case (idx)
      REG_M11_M12, REG_M22_M23, REG_M33_M41: val = ONE_LOW;
      REG_QUAT_Z_W:                          val = ONE_HIGH;
      default:                               val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== src/vtu_if.sv =====
// ----------------------------------------------------------------------------
// vtu_if
// Valid/ready channel interfaces of the vertex transform unit: the vector
// input channel and the transformed vector output channel.
// ----------------------------------------------------------------------------
interface vtu_in_if import vtu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  kind_t                  kind;
  logic signed [IO_W-1:0] x_in;
  logic signed [IO_W-1:0] y_in;
  logic signed [IO_W-1:0] z_in;

  modport source (output valid, kind, x_in, y_in, z_in, input ready);
  modport sink   (input valid, kind, x_in, y_in, z_in, output ready);
endinterface

interface vtu_out_if import vtu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] x_out;
  logic signed [IO_W-1:0] y_out;
  logic signed [IO_W-1:0] z_out;
  logic                   saturated;

  modport source (output valid, x_out, y_out, z_out, saturated, input ready);
  modport sink   (input valid, x_out, y_out, z_out, saturated, output ready);
endinterface

// ===== src/vtu_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// vtu_cfg_regs
// APB-style register file holding the matrix and quaternion coefficients,
// unpacked into one coefficient bundle for the datapath.
// ----------------------------------------------------------------------------
module vtu_cfg_regs import vtu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output coef_t                 coef
);

  logic [CFG_DATA_W-1:0] cfg_r [NUM_REGS];
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;

  // one register per 8-byte slot
  assign reg_idx = paddr[CFG_ADDR_W-1:ADDR_LSB];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign prdata  = cfg_r[reg_idx];

  // register write in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= reg_reset(reg_idx_t'(REG_IDX_W'(i)));
      end
    end else if (wr_en) begin
      cfg_r[reg_idx] <= pwdata;
    end
  end

  // coefficient unpacking, low half first
  assign coef.m[0][0] = cfg_r[REG_M11_M12][HALF_W-1:0];
  assign coef.m[0][1] = cfg_r[REG_M11_M12][CFG_DATA_W-1:HALF_W];
  assign coef.m[0][2] = cfg_r[REG_M13_M21][HALF_W-1:0];
  assign coef.m[1][0] = cfg_r[REG_M13_M21][CFG_DATA_W-1:HALF_W];
  assign coef.m[1][1] = cfg_r[REG_M22_M23][HALF_W-1:0];
  assign coef.m[1][2] = cfg_r[REG_M22_M23][CFG_DATA_W-1:HALF_W];
  assign coef.m[2][0] = cfg_r[REG_M31_M32][HALF_W-1:0];
  assign coef.m[2][1] = cfg_r[REG_M31_M32][CFG_DATA_W-1:HALF_W];
  assign coef.m[2][2] = cfg_r[REG_M33_M41][HALF_W-1:0];
  assign coef.tr[0]   = cfg_r[REG_M33_M41][CFG_DATA_W-1:HALF_W];
  assign coef.tr[1]   = cfg_r[REG_M42_M43][HALF_W-1:0];
  assign coef.tr[2]   = cfg_r[REG_M42_M43][CFG_DATA_W-1:HALF_W];
  assign coef.qx      = cfg_r[REG_QUAT_X_Y][HALF_W-1:0];
  assign coef.qy      = cfg_r[REG_QUAT_X_Y][CFG_DATA_W-1:HALF_W];
  assign coef.qz      = cfg_r[REG_QUAT_Z_W][HALF_W-1:0];
  assign coef.qw      = cfg_r[REG_QUAT_Z_W][CFG_DATA_W-1:HALF_W];

endmodule

// ===== src/vtu_stage_a.sv =====
// ----------------------------------------------------------------------------
// vtu_stage_a
// First pipeline section: nine multipliers form either the 3x3 matrix
// products or the quaternion cross products, then one rounded sum per
// component gives the matrix result or the clamped rotation vector t.
// ----------------------------------------------------------------------------
module vtu_stage_a import vtu_pkg::*; #(
  parameter int CW = 32,
  parameter int F  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  coef_t                coef,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  kind_t                in_kind,
  input  logic signed [CW-1:0] in_v [3],
  output logic                 out_valid,
  input  logic                 out_ready,
  output kind_t                out_kind,
  output logic signed [CW-1:0] out_v [3],
  output logic signed [CW-1:0] out_r [3],
  output logic signed [CW:0]   out_t [3],
  output logic                 out_sat,
  output stage_occ_t           occ
);

  localparam int PW = 2 * CW;
  localparam int TW = CW + 1;
  localparam int SW = ((2 * CW > CW + F) ? 2 * CW : CW + F) + 4;
  localparam logic signed [SW-1:0] HALF = SW'(64'sd1 <<< (F - 1));
  localparam logic signed [SW-1:0] OMAX = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] OMIN = ~OMAX;
  localparam logic signed [SW-1:0] TLIM = SW'((64'sd1 <<< CW) - 64'sd1);
  localparam logic signed [SW-1:0] TMIN = -TLIM;

  logic signed [CW-1:0] mc [3][3];
  logic signed [CW-1:0] tr [3];
  logic signed [CW-1:0] qx, qy, qz;
  logic signed [CW-1:0] op_a [9];
  logic signed [CW-1:0] op_b [9];
  logic signed [PW-1:0] prod1_nxt [9];

  logic                 v1_r, en1;
  kind_t                kind1_r;
  logic signed [CW-1:0] vin1_r [3];
  logic signed [PW-1:0] prod1_r [9];

  logic signed [SW-1:0] acc, rnd;
  logic signed [CW-1:0] r2_nxt [3];
  logic signed [TW-1:0] t2_nxt [3];
  logic                 sat2_nxt;

  logic                 v2_r, en2;
  kind_t                kind2_r;
  logic signed [CW-1:0] vin2_r [3];
  logic signed [CW-1:0] r2_r [3];
  logic signed [TW-1:0] t2_r [3];
  logic                 sat2_r;

  // coefficients at coordinate width
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        mc[j][i] = coef.m[j][i][CW-1:0];
      end
      tr[j] = coef.tr[j][CW-1:0];
    end
    qx = coef.qx[CW-1:0];
    qy = coef.qy[CW-1:0];
    qz = coef.qz[CW-1:0];
  end

  // operand select: matrix columns, or cross product pairs for rotation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        op_a[3*i+j] = in_v[j];
        op_b[3*i+j] = mc[j][i];
      end
    end
    if (in_kind == KIND_ROTATE) begin
      op_a[0] = qy; op_b[0] = in_v[2];
      op_a[1] = qz; op_b[1] = in_v[1];
      op_a[2] = qz; op_b[2] = in_v[0];
      op_a[3] = qx; op_b[3] = in_v[2];
      op_a[4] = qx; op_b[4] = in_v[1];
      op_a[5] = qy; op_b[5] = in_v[0];
    end
  end

  // multiplier bank
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      prod1_nxt[k] = op_a[k] * op_b[k];
    end
  end

  // stage 1 registers
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      kind1_r <= in_kind;
      vin1_r  <= in_v;
      prod1_r <= prod1_nxt;
    end
  end

  // exact sum, round half up, clamp
  always_comb begin
    sat2_nxt = 1'b0;
    acc      = '0;
    rnd      = '0;
    for (int i = 0; i < 3; i++) begin
      if (kind1_r == KIND_ROTATE) begin
        acc = ((SW'(prod1_r[2*i]) - SW'(prod1_r[2*i+1])) <<< 1) + HALF;
      end else begin
        acc = SW'(prod1_r[3*i]) + SW'(prod1_r[3*i+1]) + SW'(prod1_r[3*i+2]) + HALF;
        if (kind1_r == KIND_POINT) begin
          acc = acc + (SW'(tr[i]) <<< F);
        end
      end
      rnd       = acc >>> F;
      r2_nxt[i] = rnd[CW-1:0];
      t2_nxt[i] = rnd[TW-1:0];
      unique case (kind1_r)
        KIND_PASS: begin
          r2_nxt[i] = vin1_r[i];
        end
        KIND_ROTATE: begin
          if (rnd > TLIM) begin
            t2_nxt[i] = TLIM[TW-1:0];
            sat2_nxt  = 1'b1;
          end else if (rnd < TMIN) begin
            t2_nxt[i] = TMIN[TW-1:0];
            sat2_nxt  = 1'b1;
          end
        end
        KIND_POINT, KIND_NORMAL: begin
          if (rnd > OMAX) begin
            r2_nxt[i] = OMAX[CW-1:0];
            sat2_nxt  = 1'b1;
          end else if (rnd < OMIN) begin
            r2_nxt[i] = OMIN[CW-1:0];
            sat2_nxt  = 1'b1;
          end
        end
      endcase
    end
  end

  // stage 2 registers
  assign en2 = !v2_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      kind2_r <= kind1_r;
      vin2_r  <= vin1_r;
      r2_r    <= r2_nxt;
      t2_r    <= t2_nxt;
      sat2_r  <= sat2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_kind  = kind2_r;
  assign out_v     = vin2_r;
  assign out_r     = r2_r;
  assign out_t     = t2_r;
  assign out_sat   = sat2_r;
  assign occ       = '{s1: v1_r, s2: v2_r};

endmodule

// ===== src/vtu_stage_b.sv =====
// ----------------------------------------------------------------------------
// vtu_stage_b
// Second pipeline section: for rotations, v + w*t + q x t from nine
// multipliers and one rounded, saturated sum per component; other kinds
// carry their finished result through. Its last register is the output.
// ----------------------------------------------------------------------------
module vtu_stage_b import vtu_pkg::*; #(
  parameter int CW = 32,
  parameter int F  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  coef_t                coef,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  kind_t                in_kind,
  input  logic signed [CW-1:0] in_v [3],
  input  logic signed [CW-1:0] in_r [3],
  input  logic signed [CW:0]   in_t [3],
  input  logic                 in_sat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [CW-1:0] out_r [3],
  output logic                 out_sat,
  output stage_occ_t           occ
);

  localparam int TW = CW + 1;
  localparam int QW = CW + TW;
  localparam int SW = ((2 * CW > CW + F) ? 2 * CW : CW + F) + 4;
  localparam logic signed [SW-1:0] HALF = SW'(64'sd1 <<< (F - 1));
  localparam logic signed [SW-1:0] OMAX = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] OMIN = ~OMAX;

  logic signed [CW-1:0] q [3];
  logic signed [CW-1:0] qw;
  logic signed [QW-1:0] pa_nxt [3];
  logic signed [QW-1:0] pb_nxt [3];
  logic signed [QW-1:0] pc_nxt [3];

  logic                 v1_r, en1;
  logic                 rot1_r;
  logic signed [CW-1:0] vin1_r [3];
  logic signed [CW-1:0] r1_r [3];
  logic                 sat1_r;
  logic signed [QW-1:0] pa1_r [3];
  logic signed [QW-1:0] pb1_r [3];
  logic signed [QW-1:0] pc1_r [3];

  logic signed [SW-1:0] acc, rnd;
  logic signed [CW-1:0] r2_nxt [3];
  logic                 sat2_nxt;

  logic                 v2_r, en2;
  logic signed [CW-1:0] r2_r [3];
  logic                 sat2_r;

  assign q[0] = coef.qx[CW-1:0];
  assign q[1] = coef.qy[CW-1:0];
  assign q[2] = coef.qz[CW-1:0];
  assign qw   = coef.qw[CW-1:0];

  // multiplier bank: w*t and the two cross product terms per component
  for (genvar i = 0; i < 3; i++) begin : g_prod
    localparam int J1 = (i + 1) % 3;
    localparam int J2 = (i + 2) % 3;
    assign pa_nxt[i] = in_t[i] * qw;
    assign pb_nxt[i] = q[J1] * in_t[J2];
    assign pc_nxt[i] = q[J2] * in_t[J1];
  end

  // stage 1 registers
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      rot1_r <= (in_kind == KIND_ROTATE);
      vin1_r <= in_v;
      r1_r   <= in_r;
      sat1_r <= in_sat;
      pa1_r  <= pa_nxt;
      pb1_r  <= pb_nxt;
      pc1_r  <= pc_nxt;
    end
  end

  // exact sum with v, round half up, saturate
  always_comb begin
    sat2_nxt = sat1_r;
    acc      = '0;
    rnd      = '0;
    for (int i = 0; i < 3; i++) begin
      acc = (SW'(vin1_r[i]) <<< F) + SW'(pa1_r[i]) + SW'(pb1_r[i]) - SW'(pc1_r[i]) + HALF;
      rnd = acc >>> F;
      r2_nxt[i] = r1_r[i];
      if (rot1_r) begin
        if (rnd > OMAX) begin
          r2_nxt[i] = OMAX[CW-1:0];
          sat2_nxt  = 1'b1;
        end else if (rnd < OMIN) begin
          r2_nxt[i] = OMIN[CW-1:0];
          sat2_nxt  = 1'b1;
        end else begin
          r2_nxt[i] = rnd[CW-1:0];
        end
      end
    end
  end

  // stage 2 registers, the output register
  assign en2 = !v2_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      r2_r   <= r2_nxt;
      sat2_r <= sat2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_r     = r2_r;
  assign out_sat   = sat2_r;
  assign occ       = '{s1: v1_r, s2: v2_r};

endmodule

// ===== src/vertex_transform_unit.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_unit
// Transforms one 3D fixed-point vector per transaction: affine point
// transform, normal transform, quaternion rotation or pass-through, with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries kind and x_in, y_in, z_in (signed fixed point); a
//          transaction is taken when valid and ready are both high.
//   out_ch returns x_out, y_out, z_out and the saturated flag, one result
//          per input transaction, in order.
//   The APB port holds eight 64-bit coefficient registers at 8-byte
//   steps; write them only while no transaction is in flight.
// Pipeline: four register stages, two multiplier banks and two rounding
//   adders each taking one stage; a result turns valid on out_ch from the
//   last stage register. Throughput: one vector per cycle, set by the
//   fully pipelined datapath, while out_ch takes results without stalling.
// Stalls: each stage holds its data while the next one is full and held,
//   so in_ch keeps taking transactions until all four stages are occupied
//   with out_ch stalled; nothing is dropped or repeated.
// Reset: clears all stage valid bits and loads the identity matrix and the
//   unit quaternion into the registers.
// ----------------------------------------------------------------------------
module vertex_transform_unit import vtu_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vtu_in_if.sink                in_ch,
  vtu_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CW    = COORD_WIDTH;
  localparam int OCC_W = 3;

  coef_t                coef;
  logic signed [CW-1:0] v_in [3];

  logic                 ab_valid, ab_ready, ab_sat;
  kind_t                ab_kind;
  logic signed [CW-1:0] ab_v [3];
  logic signed [CW-1:0] ab_r [3];
  logic signed [CW:0]   ab_t [3];
  stage_occ_t           occ_a, occ_b;

  logic signed [CW-1:0] res [3];

  logic                 in_acc, out_acc;
  logic [OCC_W-1:0]     occ_cnt_r, occ_cnt_nxt;

  // coefficient registers
  vtu_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  // input coordinates at working width
  assign v_in[0] = in_ch.x_in[CW-1:0];
  assign v_in[1] = in_ch.y_in[CW-1:0];
  assign v_in[2] = in_ch.z_in[CW-1:0];

  // first section: matrix products or rotation vector t
  vtu_stage_a #(.CW(CW), .F(FRAC_BITS)) u_stage_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_kind   (in_ch.kind),
    .in_v      (v_in),
    .out_valid (ab_valid),
    .out_ready (ab_ready),
    .out_kind  (ab_kind),
    .out_v     (ab_v),
    .out_r     (ab_r),
    .out_t     (ab_t),
    .out_sat   (ab_sat),
    .occ       (occ_a)
  );

  // second section: rotation finish and output register
  vtu_stage_b #(.CW(CW), .F(FRAC_BITS)) u_stage_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef),
    .in_valid  (ab_valid),
    .in_ready  (ab_ready),
    .in_kind   (ab_kind),
    .in_v      (ab_v),
    .in_r      (ab_r),
    .in_t      (ab_t),
    .in_sat    (ab_sat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_r     (res),
    .out_sat   (out_ch.saturated),
    .occ       (occ_b)
  );

  // results sign-extended to the channel width
  assign out_ch.x_out = IO_W'(res[0]);
  assign out_ch.y_out = IO_W'(res[1]);
  assign out_ch.z_out = IO_W'(res[2]);

  // transactions in flight
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign out_acc     = out_ch.valid & out_ch.ready;
  assign occ_cnt_nxt = occ_cnt_r + OCC_W'(in_acc) - OCC_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_cnt_r <= '0;
    end else begin
      occ_cnt_r <= occ_cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  // an empty output stage never blocks the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with an empty output stage");

  // every accepted transaction sits in exactly one stage until delivered
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({occ_a, occ_b}) == occ_cnt_r)
    else $error("pipeline valid bits disagree with transactions in flight");

  // a stalled handoff between the two sections keeps its valid and its first r and t components
  a_handoff_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ab_valid && !ab_ready |=> ab_valid && $stable(ab_r[0]) && $stable(ab_t[0]))
    else $error("stalled transaction lost between sections");
`endif

endmodule
